>>> sv/dlpv_pkg.sv
// Shared constants, codes and control types of the decimal list parse and validate unit.
`timescale 1ns / 1ps

package dlpv_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);

    localparam int CNT_W  = 10;
    localparam int VAL_W  = 32;
    localparam int SLOT_W = 9;
    localparam int STAT_W = 2;
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int CALC_W = ((TBL_AW > CNT_W) ? TBL_AW : CNT_W) + 1;

    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    localparam logic [CMD_W-1:0] CMD_CHAR     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END_STR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END_LIST = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STAT_W-1:0] ST_DUP      = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd3;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam logic [VAL_W-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [VAL_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        PH_WS     = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    typedef struct packed {
        logic take_char;
        logic start_str;
        logic start_list;
        logic scan_rd;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic excess;
        logic scan_more;
        logic out_free;
    } t_dp_stat;

endpackage

>>> sv/dlpv_ctrl.sv
// Sequencing state machine of the decimal list parse and validate unit.
`timescale 1ns / 1ps

module dlpv_ctrl import dlpv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_command,
    output logic             o_in_stall,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    unique case (i_command)
                        CMD_CHAR: begin
                            o_cmd.take_char = 1'b1;
                        end
                        CMD_END_STR: begin
                            o_cmd.start_str = 1'b1;
                            n_state = i_stat.excess ? S_EMIT : S_SCAN;
                        end
                        CMD_END_LIST: begin
                            o_cmd.start_list = 1'b1;
                            n_state = S_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_stat.scan_more) begin
                    o_cmd.scan_rd = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/dlpv_dpath.sv
// Parser, number table, duplicate scan and result register of the decimal list unit.
`timescale 1ns / 1ps

module dlpv_dpath import dlpv_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_stat                o_stat,
    input  logic                    i_cfg_we,
    input  logic [CNT_W-1:0]        i_number_count,
    input  logic [CHAR_W-1:0]       i_character,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic signed [VAL_W-1:0] o_value,
    output logic [SLOT_W-1:0]       o_slot,
    output logic [STAT_W-1:0]       o_status,
    output logic                    o_list_done
);

    logic [VAL_W-1:0]  r_table [TABLE_DEPTH];

    logic [CNT_W-1:0]  r_number_count;
    logic [VAL_W-1:0]  r_acc;
    logic              r_ovf;
    logic              r_neg;
    t_phase            r_phase;
    logic [CNT_W-1:0]  r_stored;
    logic [STAT_W-1:0] r_sticky;
    logic              r_rd_vld;
    logic              r_out_valid;

    logic [VAL_W-1:0]  r_val;
    logic              r_in_range;
    logic              r_excess;
    logic              r_is_list;
    logic              r_dup;
    logic [CALC_W-1:0] r_slot;
    logic [CALC_W-1:0] r_top;
    logic [CALC_W-1:0] r_k;
    logic [VAL_W-1:0]  r_rd_data;
    logic [VAL_W-1:0]  r_out_value;
    logic [SLOT_W-1:0] r_out_slot;
    logic [STAT_W-1:0] r_out_status;
    logic              r_out_done;

    logic [VAL_W-1:0]  n_acc;
    logic              n_ovf;
    logic              n_neg;
    t_phase            n_phase;

    logic              w_is_digit;
    logic              w_is_ws;
    logic              w_take_digit;
    logic [3:0]        w_digit;
    logic [VAL_W+3:0]  w_prod;
    logic              w_in_range;
    logic [VAL_W-1:0]  w_val;
    logic [CNT_W-1:0]  w_diff;
    logic              w_excess;
    logic [CALC_W-1:0] w_top;
    logic [STAT_W-1:0] w_str_status;
    logic [STAT_W-1:0] w_list_status;

    assign w_is_digit = (i_character >= CH_ZERO) && (i_character <= CH_NINE);
    assign w_is_ws    = (i_character == CH_SPACE) ||
                        ((i_character >= CH_TAB) && (i_character <= CH_CR));
    assign w_digit    = 4'(i_character - CH_ZERO);
    assign w_prod     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) +
                        (VAL_W+4)'(w_digit);

    always_comb begin
        n_acc        = r_acc;
        n_ovf        = r_ovf;
        n_neg        = r_neg;
        n_phase      = r_phase;
        w_take_digit = 1'b0;
        if (i_cmd.take_char) begin
            unique case (r_phase)
                PH_WS: begin
                    if (w_is_ws) begin
                        n_phase = PH_WS;
                    end else if ((i_character == CH_MINUS) || (i_character == CH_PLUS)) begin
                        n_neg   = (i_character == CH_MINUS);
                        n_phase = PH_DIGITS;
                    end else if (w_is_digit) begin
                        w_take_digit = 1'b1;
                        n_phase      = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (w_is_digit) begin
                        w_take_digit = 1'b1;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
        end
        if (w_take_digit && !r_ovf) begin
            if (w_prod > {4'b0, MAG_LIMIT}) begin
                n_ovf = 1'b1;
                n_acc = MAG_LIMIT;
            end else begin
                n_acc = w_prod[VAL_W-1:0];
            end
        end
        if (i_cmd.emit) begin
            n_acc   = '0;
            n_ovf   = 1'b0;
            n_neg   = 1'b0;
            n_phase = PH_WS;
        end
    end

    always_comb begin
        if (r_neg) begin
            w_in_range = !r_ovf && (r_acc <= MAG_LIMIT);
            w_val      = w_in_range ? (VAL_W'(0) - r_acc) : MAG_LIMIT;
        end else begin
            w_in_range = !r_ovf && (r_acc <= POS_MAX);
            w_val      = w_in_range ? r_acc : POS_MAX;
        end
    end

    assign w_diff   = r_number_count - CNT_RESET - r_stored;
    assign w_excess = (r_stored >= r_number_count) ||
                      (CALC_W'(w_diff) >= CALC_W'(TABLE_DEPTH));
    assign w_top    = (CALC_W'(r_number_count) < CALC_W'(TABLE_DEPTH)) ?
                      CALC_W'(r_number_count) : CALC_W'(TABLE_DEPTH);

    always_comb begin
        if (r_excess) begin
            w_str_status = ST_MISMATCH;
        end else if (!r_in_range) begin
            w_str_status = ST_RANGE;
        end else if (r_dup) begin
            w_str_status = ST_DUP;
        end else begin
            w_str_status = ST_OK;
        end
    end

    assign w_list_status = (r_sticky != ST_OK) ? r_sticky :
                           ((r_stored != r_number_count) ? ST_MISMATCH : ST_OK);

    assign o_stat.excess    = w_excess;
    assign o_stat.scan_more = (r_k < r_top);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_count <= CNT_RESET;
            r_acc          <= '0;
            r_ovf          <= 1'b0;
            r_neg          <= 1'b0;
            r_phase        <= PH_WS;
            r_stored       <= '0;
            r_sticky       <= ST_OK;
            r_rd_vld       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_number_count <= i_number_count;
            end
            r_acc    <= n_acc;
            r_ovf    <= n_ovf;
            r_neg    <= n_neg;
            r_phase  <= n_phase;
            r_rd_vld <= i_cmd.scan_rd;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (r_is_list) begin
                    r_stored <= '0;
                    r_sticky <= ST_OK;
                end else begin
                    if (r_sticky == ST_OK) begin
                        r_sticky <= w_str_status;
                    end
                    if (r_stored != CNT_MAX) begin
                        r_stored <= r_stored + CNT_RESET;
                    end
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_str) begin
            r_val      <= w_val;
            r_in_range <= w_in_range;
            r_excess   <= w_excess;
            r_is_list  <= 1'b0;
            r_dup      <= 1'b0;
            r_slot     <= w_excess ? '0 : CALC_W'(w_diff);
            r_k        <= CALC_W'(w_diff) + CALC_W'(1);
            r_top      <= w_top;
        end else begin
            if (i_cmd.start_list) begin
                r_is_list <= 1'b1;
            end
            if (i_cmd.scan_rd) begin
                r_k <= r_k + CALC_W'(1);
            end
            if (r_rd_vld && (r_rd_data == r_val)) begin
                r_dup <= 1'b1;
            end
        end
        if (i_cmd.emit) begin
            if (r_is_list) begin
                r_out_value  <= '0;
                r_out_slot   <= '0;
                r_out_status <= w_list_status;
                r_out_done   <= 1'b1;
            end else begin
                r_out_value  <= r_val;
                r_out_slot   <= r_slot[SLOT_W-1:0];
                r_out_status <= w_str_status;
                r_out_done   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && !r_is_list && !r_excess) begin
            r_table[r_slot[TBL_AW-1:0]] <= r_val;
        end
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_table[r_k[TBL_AW-1:0]];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = $signed(r_out_value);
    assign o_slot      = r_out_slot;
    assign o_status    = r_out_status;
    assign o_list_done = r_out_done;

endmodule

>>> sv/decimal_list_parse_validate_unit.sv
// Top level of the decimal list parse and validate unit.
`timescale 1ns / 1ps

// Parses a list of strings, one character per transfer, into signed 32-bit
// numbers (skip whitespace, optional sign, digits up to the first non-digit,
// saturating on overflow), stores them in a 512-entry table in reversed slot
// order and checks each against those already stored. A character transfer
// produces no result. An end-of-string transfer scans the numbers already
// stored in the current list: the duplicate check reads one table entry per
// cycle through the single table read port. An end-of-list transfer, and an
// end of string beyond the expected count, skip the duplicate scan. The
// result sits in an output register, so the next item is taken while it
// waits. Write number_count only while the unit is idle; it needs no
// clearing pass after reset.
module decimal_list_parse_validate_unit import dlpv_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [CHAR_W-1:0]       i_character,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_value,
    output logic [SLOT_W-1:0]       o_slot,
    output logic [STAT_W-1:0]       o_status,
    output logic                    o_list_done,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CNT_W-1:0]        i_number_count
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    dlpv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    dlpv_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_number_count (i_number_count),
        .i_character    (i_character),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_value        (o_value),
        .o_slot         (o_slot),
        .o_status       (o_status),
        .o_list_done    (o_list_done)
    );

`ifndef SYNTH
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.emit))
        else $error("result appeared without an emit");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> (!w_cmd.scan_rd && !w_cmd.emit))
        else $error("input transfer during scan or emit");

    a_list_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_list_done) |-> ((o_value == 0) && (o_slot == 0)))
        else $error("end-of-list result carries a value or slot");
`endif

endmodule

>>> tb/sv/tb_decimal_list_parse_validate_unit.sv
// Self-checking testbench for the decimal list parse and validate unit.
`timescale 1ns / 1ps

module tb_decimal_list_parse_validate_unit;
    import dlpv_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] slot;
        logic [STAT_W-1:0] status;
        logic              list_done;
    } t_verdict;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [CMD_W-1:0]        i_command;
    logic [CHAR_W-1:0]       i_character;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [VAL_W-1:0] o_value;
    logic [SLOT_W-1:0]       o_slot;
    logic [STAT_W-1:0]       o_status;
    logic                    o_list_done;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CNT_W-1:0]        i_number_count;

    // predictor state
    logic [VAL_W-1:0]  num_tbl [TABLE_DEPTH];
    logic [CNT_W-1:0]  cfg_count;
    logic [CNT_W-1:0]  n_stored;
    logic [STAT_W-1:0] first_err;
    logic [VAL_W-1:0]  acc_mag;
    logic              acc_ovf;
    logic              acc_neg;
    t_phase            parse_ph;

    t_verdict    verdict_q [$];
    t_verdict    exp_v;
    longint      list_values [$];
    longint      limit_vals [6] = '{64'sd2147483647, 64'sd2147483648, -64'sd2147483648,
                                    -64'sd2147483649, 64'sd0, -64'sd1};
    int          mismatches = 0;
    int          items_sent = 0;
    int          send_idle_pct = 30;
    int          recv_stall_pct = 55;
    int unsigned cycle_cnt = 0;

    decimal_list_parse_validate_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_character    (i_character),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_value        (o_value),
        .o_slot         (o_slot),
        .o_status       (o_status),
        .o_list_done    (o_list_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_number_count (i_number_count)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic void restart_parser();
        acc_mag  = '0;
        acc_ovf  = 1'b0;
        acc_neg  = 1'b0;
        parse_ph = PH_WS;
    endfunction

    function automatic void accumulate_digit(input logic [CHAR_W-1:0] ch);
        logic [35:0] wide;
        if (!acc_ovf) begin
            wide = {4'd0, acc_mag} * 36'd10 + 36'(ch - CH_ZERO);
            if (wide > {4'd0, MAG_LIMIT}) begin
                acc_ovf = 1'b1;
                acc_mag = MAG_LIMIT;
            end else begin
                acc_mag = wide[31:0];
            end
        end
    endfunction

    // Advance the parser and queue the verdict, if any, that one transfer produces.
    function automatic void parse_and_validate(input logic [CMD_W-1:0] cmd,
                                               input logic [CHAR_W-1:0] ch);
        logic              is_digit;
        logic              is_space;
        logic              in_rng;
        logic              dup;
        logic [VAL_W-1:0]  val;
        logic [STAT_W-1:0] st;
        int                slot_i;
        int                top;
        int                k;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
        case (cmd)
            CMD_CHAR: begin
                if (parse_ph == PH_WS) begin
                    if (is_space) begin
                    end else if (ch == CH_MINUS || ch == CH_PLUS) begin
                        acc_neg  = (ch == CH_MINUS);
                        parse_ph = PH_DIGITS;
                    end else if (is_digit) begin
                        accumulate_digit(ch);
                        parse_ph = PH_DIGITS;
                    end else begin
                        parse_ph = PH_DONE;
                    end
                end else if (parse_ph == PH_DIGITS) begin
                    if (is_digit) accumulate_digit(ch);
                    else parse_ph = PH_DONE;
                end
            end
            CMD_END_STR: begin
                if (acc_neg) begin
                    in_rng = !acc_ovf && (acc_mag <= MAG_LIMIT);
                    val    = in_rng ? (32'd0 - acc_mag) : MAG_LIMIT;
                end else begin
                    in_rng = !acc_ovf && (acc_mag <= POS_MAX);
                    val    = in_rng ? acc_mag : POS_MAX;
                end
                slot_i = 0;
                st     = ST_OK;
                if (n_stored >= cfg_count ||
                    int'(cfg_count) - 1 - int'(n_stored) >= TABLE_DEPTH) begin
                    st = ST_MISMATCH;
                end else begin
                    top    = (int'(cfg_count) < TABLE_DEPTH) ? int'(cfg_count) : TABLE_DEPTH;
                    slot_i = int'(cfg_count) - 1 - int'(n_stored);
                    dup    = 1'b0;
                    for (k = slot_i + 1; k < top; k++) begin
                        if (num_tbl[k] == val) dup = 1'b1;
                    end
                    num_tbl[slot_i] = val;
                    if (!in_rng) st = ST_RANGE;
                    else if (dup) st = ST_DUP;
                end
                if (first_err == ST_OK) first_err = st;
                if (n_stored != CNT_MAX) n_stored = n_stored + 1'b1;
                restart_parser();
                verdict_q.push_back('{value: val, slot: SLOT_W'(slot_i), status: st,
                                      list_done: 1'b0});
            end
            CMD_END_LIST: begin
                st = first_err;
                if (st == ST_OK && n_stored != cfg_count) st = ST_MISMATCH;
                n_stored  = '0;
                first_err = ST_OK;
                restart_parser();
                verdict_q.push_back('{value: '0, slot: '0, status: st, list_done: 1'b1});
            end
            default: begin
            end
        endcase
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_character <= ch;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        parse_and_validate(cmd, ch);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_item(CMD_CHAR, s[i]);
    endtask

    task automatic end_string();
        send_item(CMD_END_STR, CHAR_W'($urandom_range(255)));
    endtask

    task automatic end_list();
        send_item(CMD_END_LIST, CHAR_W'($urandom_range(255)));
    endtask

    task automatic wait_results_settled();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_number_count(input logic [CNT_W-1:0] n);
        wait_results_settled();
        i_cfg_valid    <= 1'b1;
        i_number_count <= n;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_count = n;
    endtask

    task automatic send_decimal(input longint v);
        string  digits;
        longint mag;
        int     i;
        mag = (v < 0) ? -v : v;
        if (v < 0) send_item(CMD_CHAR, CH_MINUS);
        else if ($urandom_range(3) == 0) send_item(CMD_CHAR, CH_PLUS);
        if ($urandom_range(5) == 0) repeat ($urandom_range(1, 3)) send_item(CMD_CHAR, CH_ZERO);
        digits = $sformatf("%0d", mag);
        for (i = 0; i < digits.len(); i++) send_item(CMD_CHAR, digits[i]);
    endtask

    task automatic send_random_string();
        int               kind;
        int               pick;
        longint           v;
        logic [CHAR_W-1:0] c;
        kind = $urandom_range(99);
        repeat ($urandom_range(2)) begin
            pick = $urandom_range(6);
            send_item(CMD_CHAR, (pick == 6) ? CH_SPACE : CH_TAB + CHAR_W'(pick));
        end
        if (kind < 12) begin
            repeat ($urandom_range(6)) send_item(CMD_CHAR, CHAR_W'($urandom_range(255)));
        end else if (kind < 22) begin
            if ($urandom_range(1) == 0) send_item(CMD_CHAR, CH_MINUS);
            repeat ($urandom_range(10, 20))
                send_item(CMD_CHAR, CH_ZERO + CHAR_W'($urandom_range(9)));
        end else begin
            if (kind < 40 && list_values.size() > 0)
                v = list_values[$urandom_range(list_values.size() - 1)];
            else if (kind < 50)
                v = limit_vals[$urandom_range(5)];
            else if (kind < 75)
                v = longint'($urandom_range(40)) - 20;
            else
                v = longint'($signed($urandom()));
            list_values.push_back(v);
            send_decimal(v);
            if ($urandom_range(2) == 0) begin
                c = CHAR_W'($urandom_range(255));
                if (c >= CH_ZERO && c <= CH_NINE) c = CH_SPACE;
                send_item(CMD_CHAR, c);
                repeat ($urandom_range(3)) send_item(CMD_CHAR, CHAR_W'($urandom_range(255)));
            end
        end
        if ($urandom_range(19) == 0) send_item(CMD_UNUSED, CHAR_W'($urandom_range(255)));
        end_string();
    endtask

    task automatic test_reset_count();
        send_text("42");
        end_string();
        end_list();
        end_list();
        send_text("7");
        end_string();
        send_text("7");
        end_string();
        end_list();
    endtask

    task automatic test_parse_forms();
        logic [CHAR_W-1:0] c;
        write_number_count(CNT_W'(6));
        send_item(CMD_CHAR, CH_SPACE);
        for (c = CH_TAB; c <= CH_CR; c++) send_item(CMD_CHAR, c);
        send_text("-17");
        end_string();
        send_text("+25x9");
        end_string();
        send_text("-");
        end_string();
        send_text("q12");
        end_string();
        send_item(CMD_CHAR, 8'hFF);
        send_text("5");
        end_string();
        send_text("1");
        send_item(CMD_UNUSED, 8'h80);
        send_text("2 34");
        end_string();
        end_list();
    endtask

    task automatic test_range_limits();
        write_number_count(CNT_W'(8));
        send_text("2147483647");
        end_string();
        send_text("2147483648");
        end_string();
        send_text("-2147483648");
        end_string();
        send_text("-2147483649");
        end_string();
        send_text("99999999999999");
        end_string();
        send_text("-000000000000000000123");
        end_string();
        send_text("4294967306");
        end_string();
        send_text("-99999999999");
        end_string();
        end_list();
    endtask

    task automatic test_count_extremes();
        write_number_count(CNT_W'(TABLE_DEPTH));
        send_text("1");
        end_string();
        send_text("2");
        end_string();
        send_text("1");
        end_string();
        end_list();
        write_number_count(CNT_W'(600));
        send_text("5");
        end_string();
        send_text("6");
        end_string();
        end_list();
        write_number_count(CNT_MAX);
        send_text("3");
        end_string();
        end_list();
        write_number_count('0);
        send_text("8");
        end_string();
        end_list();
        end_list();
        write_number_count(CNT_W'(2));
        send_text("11");
        end_string();
        send_text("99");
        end_string();
        send_text("5");
        end_list();
    endtask

    task automatic test_random_lists(input int item_goal);
        int start;
        int n;
        int r;
        start = items_sent;
        while (items_sent - start < item_goal) begin
            if ($urandom_range(3) == 0) write_number_count(CNT_W'($urandom_range(1, 12)));
            n = int'(cfg_count);
            r = $urandom_range(9);
            if (r == 0) n = n + 1;
            else if (r == 1 && n > 0) n = n - 1;
            list_values.delete();
            repeat (n) send_random_string();
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 4)) send_item(CMD_CHAR, CHAR_W'($urandom_range(255)));
            end_list();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result value %0d slot %0d status %0d list_done %0b",
                         $time, o_value, o_slot, o_status, o_list_done);
                mismatches++;
            end else begin
                exp_v = verdict_q.pop_front();
                if (o_value !== exp_v.value) begin
                    $display("%0t: value expected %0d actual %0d",
                             $time, $signed(exp_v.value), o_value);
                    mismatches++;
                end
                if (o_slot !== exp_v.slot) begin
                    $display("%0t: slot expected %0d actual %0d", $time, exp_v.slot, o_slot);
                    mismatches++;
                end
                if (o_status !== exp_v.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_v.status, o_status);
                    mismatches++;
                end
                if (o_list_done !== exp_v.list_done) begin
                    $display("%0t: list_done expected %0b actual %0b",
                             $time, exp_v.list_done, o_list_done);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL decimal_list_parse_validate_unit");
        $finish;
    end

    initial begin
        foreach (num_tbl[k]) num_tbl[k] = '0;
        cfg_count = CNT_RESET;
        n_stored  = '0;
        first_err = ST_OK;
        restart_parser();
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_command      <= CMD_CHAR;
        i_character    <= '0;
        i_cfg_valid    <= 1'b0;
        i_number_count <= CNT_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 30;
        recv_stall_pct = 55;
        test_reset_count();
        test_parse_forms();
        test_range_limits();
        test_count_extremes();
        test_random_lists(140);

        wait_results_settled();
        send_idle_pct  = 55;
        recv_stall_pct = 30;
        test_random_lists(140);

        wait_results_settled();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_lists(140);

        wait_results_settled();
        if (mismatches == 0) begin
            $display("PASS decimal_list_parse_validate_unit");
        end else begin
            $display("FAIL decimal_list_parse_validate_unit");
        end
        $finish;
    end

endmodule
